>>> rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and codes for the scanline polygon fill block.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int MAX_RESULTS = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	localparam logic [1:0] STAT_SPAN    = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_DONE    = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BSTART,
		ST_BWAIT,
		ST_BEDGE,
		ST_BDIV,
		ST_BNEXT,
		ST_SWAIT,
		ST_SUPD,
		ST_SPAIR,
		ST_SFIN,
		ST_ERR,
		ST_DONE
	} spf_state_t;

	typedef enum logic [2:0] {
		PUSH_ERR,
		PUSH_DONE,
		PUSH_EMPTY,
		PUSH_SPAN_MORE,
		PUSH_SPAN_LAST
	} push_sel_t;

	typedef struct packed {
		logic      load;
		logic      bi_init;
		logic      bi_next;
		logic      edge_calc;
		logic      edge_write;
		logic      build_done;
		logic      scan_init;
		logic      scan_upd;
		logic      pair_take;
		logic      push;
		push_sel_t push_sel;
		logic      line_inc;
	} spf_cmd_t;

	typedef struct packed {
		logic nv_small;
		logic bi_end;
		logic edge_flat;
		logic div_done;
		logic ready;
		logic past_top;
		logic scan_end;
		logic can_pair;
		logic pair_ok;
		logic pend;
		logic slot_free;
	} spf_sts_t;

endpackage

>>> rtl/scanline_polygon_fill.sv
// Closing vertex: build start, then per polygon edge an edge RAM read, the edge
// calculation, the serial slope divider (skipped for flat edges) and the edge write.
// Scanline step: accept, then per built edge an edge RAM read and then update and
// sort insert, leave the edge loop, take each x pair, and close; a result may
// also wait in the output register. Asynchronous reset clears control state.
// ----------------------------------------------------------------------------
// scanline_polygon_fill
// Scanline polygon fill with an active edge table, spans reported per line.
// ----------------------------------------------------------------------------
module scanline_polygon_fill #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS   = 10,
	parameter int FRAC_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  last_vertex,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] scan_line,
	output logic [COORD_BITS-1:0] span_first,
	output logic [COORD_BITS-1:0] span_final,
	output logic [1:0]            status,
	output logic                  last_of_run
);

	import spf_pkg::*;

	spf_cmd_t cmd;
	spf_sts_t sts;

	spf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.last_vertex (last_vertex),
		.sts         (sts),
		.cmd         (cmd)
	);

	spf_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scan_line   (scan_line),
		.span_first  (span_first),
		.span_final  (span_final),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

>>> rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/spf_div.sv
// ----------------------------------------------------------------------------
// spf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_div #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COORD_BITS+FRAC_BITS-1:0] dividend,
	input  logic [COORD_BITS-1:0]           divisor,
	output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
	output logic                            done
);

	localparam int DW   = COORD_BITS + FRAC_BITS;
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] dv_q;
	logic [DW-1:0]   dq_q;
	logic [COORD_BITS:0] rs;
	logic [COORD_BITS:0] diff;
	logic            ge;

	assign rs   = {rem_q, dq_q[DW-1]};
	assign ge   = rs >= {1'b0, dv_q};
	assign diff = rs - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_BITS-1:0] : rs[COORD_BITS-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

>>> rtl/spf_datapath.sv
// ----------------------------------------------------------------------------
// spf_datapath
// Vertex and edge stores, slope divider, active x sorter, span pairing and
// the output register.
// ----------------------------------------------------------------------------
module spf_datapath #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS   = 10,
	parameter int FRAC_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spf_pkg::spf_cmd_t     cmd,
	output spf_pkg::spf_sts_t     sts,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  last_vertex,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] scan_line,
	output logic [COORD_BITS-1:0] span_first,
	output logic [COORD_BITS-1:0] span_final,
	output logic [1:0]            status,
	output logic                  last_of_run
);

	import spf_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int XW  = C + F + 2;
	localparam int RW  = C + 2;
	localparam int DW  = C + F;
	localparam int EW  = 2 * XW + 2 * C;
	localparam int FW  = $clog2(MAX_RESULTS + 1);
	localparam logic signed [XW-1:0] HALF = XW'(1) <<< (F - 1);

	// Vertex bookkeeping.
	logic [CW-1:0] vcnt_q, nv_q, bi_q, etot_q, si_q, scnt_q;
	logic [C-1:0]  ymin_q, ymax_q, x0_q, y0_q, prev_x_q, prev_y_q;
	logic [C:0]    cur_line_q;
	logic [C-1:0]  top_q;
	logic          ready_q;
	logic [MAX_VERTICES-1:0] act_q;

	// Edge under construction.
	logic [C-1:0] e_lox_q, e_loy_q, e_hiy_q;
	logic         e_neg_q;

	// Sorted active x values and the span waiting for its successor.
	logic signed [XW-1:0] xs_q [MAX_VERTICES];
	logic signed [XW-1:0] xs_ins [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] gt;
	logic [C-1:0]  pf_q, pl_q;
	logic          pend_q;
	logic [FW-1:0] found_q;

	logic          out_valid_q;
	logic [C-1:0]  line_q, first_q, final_q;
	logic [1:0]    status_q;
	logic          last_q;

	// Vertex RAM.
	logic          store;
	logic          bi_end;
	logic [CW-1:0] new_cnt;
	logic [2*C-1:0] v_rdata;
	logic [C-1:0]  cur_x, cur_y, lox, loy, hix, hiy, adx, dy;
	logic [C:0]    dx;
	logic          lo_prev;

	// Edge RAM.
	logic          e_we;
	logic [AW-1:0] e_waddr;
	logic [EW-1:0] e_wdata, e_rdata;
	logic signed [XW-1:0] r_x, r_s, nx, slope;
	logic [C-1:0]  r_lo, r_top, y;
	logic          a_cur;

	logic [DW-1:0] quo;
	logic          div_done;

	logic signed [RW-1:0] r0, r1;
	logic signed [XW-1:0] t0, t1;
	logic signed [RW:0]   pa, pb;

	assign store   = vcnt_q < CW'(MAX_VERTICES);
	assign new_cnt = store ? vcnt_q + 1'b1 : vcnt_q;
	assign y       = cur_line_q[C-1:0];
	assign bi_end  = bi_q == nv_q;

	spf_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_vram (
		.clk   (clk),
		.we    (cmd.load && store),
		.waddr (vcnt_q[AW-1:0]),
		.wdata ({vertex_x, vertex_y}),
		.raddr (bi_q[AW-1:0]),
		.rdata (v_rdata)
	);

	// The closing edge runs from the last stored vertex back to vertex zero.
	assign cur_x   = bi_end ? x0_q : v_rdata[2*C-1:C];
	assign cur_y   = bi_end ? y0_q : v_rdata[C-1:0];
	assign lo_prev = prev_y_q < cur_y;
	assign lox     = lo_prev ? prev_x_q : cur_x;
	assign loy     = lo_prev ? prev_y_q : cur_y;
	assign hix     = lo_prev ? cur_x : prev_x_q;
	assign hiy     = lo_prev ? cur_y : prev_y_q;
	assign dx      = {1'b0, hix} - {1'b0, lox};
	assign adx     = dx[C] ? C'(-dx) : dx[C-1:0];
	assign dy      = hiy - loy;

	spf_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.edge_calc && !sts.edge_flat),
		.dividend ({adx, {F{1'b0}}}),
		.divisor  (dy),
		.quotient (quo),
		.done     (div_done)
	);

	assign slope = e_neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

	assign r_x   = e_rdata[EW-1 -: XW];
	assign r_s   = e_rdata[EW-XW-1 -: XW];
	assign r_lo  = e_rdata[2*C-1:C];
	assign r_top = e_rdata[C-1:0];
	assign nx    = r_x + r_s;
	assign a_cur = act_q[si_q[AW-1:0]];

	always_comb begin
		e_we    = cmd.edge_write || (cmd.scan_upd && a_cur);
		e_waddr = cmd.scan_upd ? si_q[AW-1:0] : etot_q[AW-1:0];
		if (cmd.scan_upd) begin
			e_wdata = {nx, r_s, r_lo, r_top};
		end else begin
			e_wdata = {$signed({2'b00, e_lox_q, {F{1'b0}}}), slope, e_loy_q, e_hiy_q};
		end
	end

	spf_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_eram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (si_q[AW-1:0]),
		.rdata (e_rdata)
	);

	// Insertion into the sorted row: every cell compares against the new x,
	// and the cells above the insertion point take their lower neighbor.
	always_comb begin
		for (int k = 0; k < MAX_VERTICES; k++) begin
			gt[k] = (CW'(k) < scnt_q) && (xs_q[k] > nx);
		end
		for (int k = 0; k < MAX_VERTICES; k++) begin
			if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
				xs_ins[k] = xs_q[(k > 0) ? k - 1 : 0];
			end else if (gt[k] || CW'(k) == scnt_q) begin
				xs_ins[k] = nx;
			end else begin
				xs_ins[k] = xs_q[k];
			end
		end
	end

	// Round to nearest by adding one half and flooring.
	assign t0 = (xs_q[0] + HALF) >>> F;
	assign t1 = (xs_q[1] + HALF) >>> F;
	assign r0 = t0[RW-1:0];
	assign r1 = t1[RW-1:0];
	assign pa = {r0[RW-1], r0} + (RW+1)'(1);
	assign pb = {r1[RW-1], r1} - (RW+1)'(1);

	always_comb begin
		sts.nv_small  = nv_q < CW'(3);
		sts.bi_end    = bi_end;
		sts.edge_flat = cur_y == prev_y_q;
		sts.div_done  = div_done;
		sts.ready     = ready_q;
		sts.past_top  = cur_line_q > {1'b0, top_q};
		sts.scan_end  = si_q == etot_q;
		sts.can_pair  = (scnt_q >= CW'(2)) && (found_q < FW'(MAX_RESULTS));
		sts.pair_ok   = pa <= pb;
		sts.pend      = pend_q;
		sts.slot_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q     <= '0;
			nv_q       <= '0;
			bi_q       <= '0;
			etot_q     <= '0;
			si_q       <= '0;
			scnt_q     <= '0;
			cur_line_q <= '0;
			top_q      <= '0;
			ready_q    <= 1'b0;
			act_q      <= '0;
			pend_q     <= 1'b0;
			found_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (vcnt_q == '0 && !last_vertex) begin
					ready_q <= 1'b0;
					act_q   <= '0;
				end
				if (last_vertex) begin
					vcnt_q  <= '0;
					nv_q    <= new_cnt;
					etot_q  <= '0;
					act_q   <= '0;
					ready_q <= 1'b0;
				end else begin
					vcnt_q <= new_cnt;
				end
			end
			if (cmd.bi_init) begin
				bi_q <= CW'(1);
			end
			if (cmd.bi_next) begin
				bi_q <= bi_q + 1'b1;
			end
			if (cmd.edge_write) begin
				etot_q <= etot_q + 1'b1;
			end
			if (cmd.build_done) begin
				cur_line_q <= {1'b0, ymin_q};
				top_q      <= ymax_q;
				ready_q    <= 1'b1;
			end
			if (cmd.scan_init) begin
				si_q    <= '0;
				scnt_q  <= '0;
				pend_q  <= 1'b0;
				found_q <= '0;
			end
			if (cmd.scan_upd) begin
				act_q[si_q[AW-1:0]] <= (a_cur && r_top != y) || r_lo == y;
				si_q <= si_q + 1'b1;
				if (a_cur) begin
					scnt_q <= scnt_q + 1'b1;
				end
			end
			if (cmd.pair_take) begin
				scnt_q <= scnt_q - CW'(2);
				if (sts.pair_ok) begin
					pend_q  <= 1'b1;
					found_q <= found_q + 1'b1;
				end
			end
			if (cmd.line_inc) begin
				cur_line_q <= cur_line_q + 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && vcnt_q == '0) begin
			x0_q     <= vertex_x;
			y0_q     <= vertex_y;
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
			ymin_q   <= vertex_y;
			ymax_q   <= vertex_y;
		end else if (cmd.load && store) begin
			if (vertex_y < ymin_q) begin
				ymin_q <= vertex_y;
			end
			if (vertex_y > ymax_q) begin
				ymax_q <= vertex_y;
			end
		end
		if (cmd.edge_calc) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
			e_lox_q  <= lox;
			e_loy_q  <= loy;
			e_hiy_q  <= hiy;
			e_neg_q  <= dx[C];
		end
		if (cmd.scan_upd && a_cur) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				xs_q[k] <= xs_ins[k];
			end
		end
		if (cmd.pair_take) begin
			for (int k = 0; k < MAX_VERTICES - 2; k++) begin
				xs_q[k] <= xs_q[k + 2];
			end
			if (sts.pair_ok) begin
				pf_q <= pa[RW] ? '0 : pa[C-1:0];
				pl_q <= pb[RW] ? '0 : pb[C-1:0];
			end
		end
		if (cmd.push) begin
			case (cmd.push_sel)
				PUSH_ERR: begin
					line_q   <= '0;
					first_q  <= '0;
					final_q  <= '0;
					status_q <= STAT_INVALID;
					last_q   <= 1'b1;
				end
				PUSH_DONE: begin
					line_q   <= top_q;
					first_q  <= '0;
					final_q  <= '0;
					status_q <= STAT_DONE;
					last_q   <= 1'b1;
				end
				PUSH_SPAN_MORE, PUSH_SPAN_LAST: begin
					line_q   <= y;
					first_q  <= pf_q;
					final_q  <= pl_q;
					status_q <= STAT_SPAN;
					last_q   <= cmd.push_sel == PUSH_SPAN_LAST;
				end
				default: begin
					line_q   <= y;
					first_q  <= '0;
					final_q  <= '0;
					status_q <= STAT_EMPTY;
					last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign scan_line   = line_q;
	assign span_first  = first_q;
	assign span_final  = final_q;
	assign status      = status_q;
	assign last_of_run = last_q;

endmodule

>>> rtl/spf_ctrl.sv
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer for vertex loading, edge table build and scanline processing.
// ----------------------------------------------------------------------------
module spf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	input  logic              last_vertex,
	input  spf_pkg::spf_sts_t sts,
	output spf_pkg::spf_cmd_t cmd
);

	import spf_pkg::*;

	spf_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_LOAD) begin
						state_nxt = last_vertex ? ST_BSTART : ST_IDLE;
					end else if (!sts.ready) begin
						state_nxt = ST_ERR;
					end else if (sts.past_top) begin
						state_nxt = ST_DONE;
					end else begin
						state_nxt = ST_SWAIT;
					end
				end
			end
			ST_BSTART: state_nxt = sts.nv_small ? ST_IDLE : ST_BWAIT;
			ST_BWAIT:  state_nxt = ST_BEDGE;
			ST_BEDGE:  state_nxt = sts.edge_flat ? ST_BNEXT : ST_BDIV;
			ST_BDIV: begin
				if (sts.div_done) begin
					state_nxt = ST_BNEXT;
				end
			end
			ST_BNEXT:  state_nxt = sts.bi_end ? ST_IDLE : ST_BWAIT;
			ST_SWAIT:  state_nxt = sts.scan_end ? ST_SPAIR : ST_SUPD;
			ST_SUPD:   state_nxt = ST_SWAIT;
			ST_SPAIR: begin
				if (!sts.can_pair) begin
					state_nxt = ST_SFIN;
				end
			end
			ST_SFIN, ST_ERR, ST_DONE: begin
				if (sts.slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.push_sel = PUSH_EMPTY;
		in_ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load      = opcode == OP_LOAD;
					cmd.scan_init = opcode == OP_SCAN && sts.ready && !sts.past_top;
				end
			end
			ST_BSTART: cmd.bi_init = !sts.nv_small;
			ST_BEDGE:  cmd.edge_calc = 1'b1;
			ST_BDIV:   cmd.edge_write = sts.div_done;
			ST_BNEXT: begin
				cmd.build_done = sts.bi_end;
				cmd.bi_next    = !sts.bi_end;
			end
			ST_SWAIT: ;
			ST_SUPD:  cmd.scan_upd = 1'b1;
			ST_SPAIR: begin
				// A new span releases the held one, which then cannot be the last.
				if (sts.can_pair) begin
					if (sts.pair_ok && sts.pend) begin
						cmd.pair_take = sts.slot_free;
						cmd.push      = sts.slot_free;
						cmd.push_sel  = PUSH_SPAN_MORE;
					end else begin
						cmd.pair_take = 1'b1;
					end
				end
			end
			ST_SFIN: begin
				cmd.push     = sts.slot_free;
				cmd.line_inc = sts.slot_free;
				cmd.push_sel = sts.pend ? PUSH_SPAN_LAST : PUSH_EMPTY;
			end
			ST_ERR: begin
				cmd.push     = sts.slot_free;
				cmd.push_sel = PUSH_ERR;
			end
			ST_DONE: begin
				cmd.push     = sts.slot_free;
				cmd.push_sel = PUSH_DONE;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/spf_checker.sv
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks on the result channel of the polygon fill block.
// ----------------------------------------------------------------------------
module spf_checker #(
	parameter int COORD_BITS = 10
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] scan_line,
	input logic [COORD_BITS-1:0] span_first,
	input logic [COORD_BITS-1:0] span_final,
	input logic [1:0]            status,
	input logic                  last_of_run
);

	import spf_pkg::*;

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scan_line) &&
		$stable(span_first) && $stable(span_final) && $stable(status))
		else $error("result changed while stalled");

	// Every result other than a span closes its step on its own.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_SPAN |-> last_of_run &&
		span_first == '0 && span_final == '0)
		else $error("status result not alone or carries a span");

	// An invalid polygon reports line zero.
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_INVALID |-> scan_line == '0)
		else $error("invalid polygon result has a line");

	// Spans are never empty.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_SPAN |-> span_first <= span_final)
		else $error("empty span reported");

endmodule

bind scanline_polygon_fill spf_checker #(.COORD_BITS(COORD_BITS)) u_spf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.scan_line   (scan_line),
	.span_first  (span_first),
	.span_final  (span_final),
	.status      (status),
	.last_of_run (last_of_run)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertex loads and scanline steps into the polygon fill block and
// checks every result against an in-bench active edge table predictor.
// ----------------------------------------------------------------------------
import spf_pkg::*;

typedef struct packed {
	logic [9:0] line;
	logic [9:0] first;
	logic [9:0] final_x;
	logic [1:0] stat;
	logic       last;
} span_rec_t;

class span_scoreboard;
	logic [9:0]  vx [16];
	logic [9:0]  vy [16];
	int          nvert;
	longint      ex [16];
	longint      eslope [16];
	logic [9:0]  elow [16];
	logic [9:0]  etop [16];
	bit          eact [16];
	int          nedge;
	int          cur_line;
	int          top;
	bit          ready;
	span_rec_t   pending [$];
	int          errors;

	function new();
		nvert = 0;
		nedge = 0;
		cur_line = 0;
		top = 0;
		ready = 0;
		errors = 0;
		foreach (eact[i]) eact[i] = 0;
	endfunction

	function longint round_q16(longint v);
		longint t;
		t = v + 32768;
		return t >>> 16;
	endfunction

	function void push_rec(int ln, int f, int l, logic [1:0] s, bit last);
		span_rec_t r;
		r.line = ln[9:0];
		r.first = f[9:0];
		r.final_x = l[9:0];
		r.stat = s;
		r.last = last;
		pending = {pending, r};
	endfunction

	function void close_polygon();
		int n, lo, hi, j, ymin, ymax;
		longint dx, dy, mag;
		n = nvert;
		nvert = 0;
		nedge = 0;
		foreach (eact[i]) eact[i] = 0;
		if (n < 3) begin
			ready = 0;
			return;
		end
		ymin = vy[0];
		ymax = vy[0];
		for (int i = 1; i < n; i++) begin
			if (vy[i] < ymin) ymin = vy[i];
			if (vy[i] > ymax) ymax = vy[i];
		end
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			if (vy[i] == vy[j]) continue;
			lo = (vy[i] < vy[j]) ? i : j;
			hi = (lo == i) ? j : i;
			dx = longint'(vx[hi]) - longint'(vx[lo]);
			dy = longint'(vy[hi]) - longint'(vy[lo]);
			mag = ((dx < 0 ? -dx : dx) * 65536) / dy;
			eslope[nedge] = dx < 0 ? -mag : mag;
			ex[nedge] = longint'(vx[lo]) * 65536;
			elow[nedge] = vy[lo];
			etop[nedge] = vy[hi];
			nedge++;
		end
		cur_line = ymin;
		top = ymax;
		ready = 1;
	endfunction

	// Notes one accepted input transfer and queues what it should produce.
	function void note_input(logic op, logic [9:0] x, logic [9:0] y, logic lastv);
		longint xs [$];
		longint a, b;
		int k;
		if (op == OP_LOAD) begin
			if (nvert == 0) begin
				ready = 0;
				foreach (eact[i]) eact[i] = 0;
			end
			if (nvert < 16) begin
				vx[nvert] = x;
				vy[nvert] = y;
				nvert++;
			end
			if (lastv) close_polygon();
			return;
		end
		if (!ready) begin
			push_rec(0, 0, 0, STAT_INVALID, 1);
			return;
		end
		if (cur_line > top) begin
			push_rec(top, 0, 0, STAT_DONE, 1);
			return;
		end
		for (int i = 0; i < nedge; i++)
			if (eact[i]) begin
				ex[i] += eslope[i];
				xs = {xs, ex[i]};
			end
		xs.sort();
		k = 0;
		for (int i = 0; i + 1 < xs.size() && k < MAX_RESULTS; i += 2) begin
			a = round_q16(xs[i]) + 1;
			b = round_q16(xs[i + 1]) - 1;
			if (a <= b) begin
				push_rec(cur_line, a < 0 ? 0 : int'(a), b < 0 ? 0 : int'(b), STAT_SPAN, 0);
				k++;
			end
		end
		if (k == 0) push_rec(cur_line, 0, 0, STAT_EMPTY, 1);
		else pending[$].last = 1;
		for (int i = 0; i < nedge; i++)
			if (eact[i] && etop[i] == cur_line) eact[i] = 0;
		for (int i = 0; i < nedge; i++)
			if (elow[i] == cur_line) eact[i] = 1;
		cur_line++;
	endfunction

	function void check_result(span_rec_t got);
		span_rec_t want;
		if (pending.size() == 0) begin
			$error("unexpected result line=%0d status=%0d", got.line, got.stat);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.line !== want.line) begin
			$error("scan_line: expected %0d, got %0d", want.line, got.line);
			errors++;
		end
		if (got.first !== want.first) begin
			$error("span_first: expected %0d, got %0d", want.first, got.first);
			errors++;
		end
		if (got.final_x !== want.final_x) begin
			$error("span_final: expected %0d, got %0d", want.final_x, got.final_x);
			errors++;
		end
		if (got.stat !== want.stat) begin
			$error("status: expected %0d, got %0d", want.stat, got.stat);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last_of_run: expected %0d, got %0d", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	logic       opcode = 0;
	logic [9:0] vertex_x = 0;
	logic [9:0] vertex_y = 0;
	logic       last_vertex = 0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [9:0] scan_line, span_first, span_final;
	logic [1:0] status;
	logic       last_of_run;

	span_scoreboard board = new();
	int  send_idle_pct = 7;
	int  recv_idle_pct = 73;
	bit  hold_off = 0;
	int  quiet_cycles = 0;
	int  items_sent = 0;

	scanline_polygon_fill dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.scan_line(scan_line), .span_first(span_first), .span_final(span_final),
		.status(status), .last_of_run(last_of_run)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			board.note_input(opcode, vertex_x, vertex_y, last_vertex);
		if (out_valid && out_ready)
			board.check_result({scan_line, span_first, span_final, status, last_of_run});
	end

	// Receiver: random stalls, or a forced long stall when hold_off is set.
	always @(negedge clk) begin
		if (hold_off) out_ready <= 0;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Valid stays high between back-to-back items and drops only for idle gaps.
	task automatic send(logic op, logic [9:0] x, logic [9:0] y, logic lastv);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1;
		opcode <= op;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= lastv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_vertex(int x, int y, bit lastv);
		send(OP_LOAD, x[9:0], y[9:0], lastv);
	endtask

	task automatic scan(int n);
		for (int i = 0; i < n; i++)
			send(OP_SCAN, 10'($urandom), 10'($urandom), 1'($urandom_range(1)));
	endtask

	// Random polygon of n vertices; small heights keep the scan short.
	task automatic random_polygon(int n, int yspan);
		int base;
		base = $urandom_range(1023 - yspan);
		for (int i = 0; i < n; i++)
			load_vertex($urandom_range(1023), base + $urandom_range(yspan), i == n - 1);
	endtask

	task automatic random_phase(int count);
		int n;
		while (count > 0) begin
			if ($urandom_range(9) == 0) begin
				scan(1);
				count--;
			end else begin
				n = $urandom_range(3, 18);
				if ($urandom_range(9) == 0) n = $urandom_range(1, 2);
				random_polygon(n, $urandom_range(1, 12));
				scan($urandom_range(3, 16));
				count -= n + 8;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: not ready, triangle with extremes, empty lines, done.
		scan(1);
		load_vertex(0, 0, 0);
		load_vertex(1023, 0, 0);
		load_vertex(512, 1023, 1);
		scan(3);
		// Thin sliver gives empty lines; horizontal edge and done status.
		load_vertex(10, 1020, 0);
		load_vertex(11, 1023, 0);
		load_vertex(12, 1020, 1);
		scan(6);
		// Two vertices only leaves the polygon invalid.
		load_vertex(5, 5, 0);
		load_vertex(6, 9, 1);
		scan(1);

		random_phase(100);

		// Long receiver stall while the sender keeps offering vertex loads and scan steps.
		hold_off = 1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			begin
				random_polygon(16, 4);
				scan(6);
			end
		join

		send_idle_pct = 73;
		recv_idle_pct = 7;
		random_phase(95);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(95);
		in_valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
